@@ rtl/core/ptt_pkg.sv @@
package ptt_pkg;
  localparam int unsigned NumTimersDefault = 16;
  localparam int unsigned TimeBitsDefault  = 48;
  localparam int unsigned RegW    = 31;
  localparam int unsigned IdW     = 4;
  localparam int unsigned RepW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;
  localparam logic [1:0] ReqTick   = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StNoTmr  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgMinInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinTimeout  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch request, clear scan state
    logic scan_en;   // visit current slot
    logic finish;    // apply add / remove
    logic emit_adv;  // advance pending fire list
  } ptt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic fire_pend;   // a fired id still to report
    logic fire_single; // exactly one fired id left
  } ptt_stat_t;
endpackage

@@ rtl/core/ptt_ctrl.sv @@
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      out_last_o,
  output logic      out_fire_o,
  input  ptt_stat_t stat_i,
  output ptt_cmd_t  cmd_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SFin  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  logic [1:0] state_q, state_d;
  logic out_xfer;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_fire_o  = stat_i.fire_pend;
  assign out_last_o  = !stat_i.fire_pend || stat_i.fire_single;

  // sequencing: scan all slots, apply, then drain results
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.start = 1'b1;
        state_d = SScan;
      end
      SScan: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_last) state_d = SFin;
      end
      SFin: begin
        cmd_o.finish = 1'b1;
        state_d = SOut;
      end
      SOut: if (out_xfer) begin
        cmd_o.emit_adv = 1'b1;
        if (out_last_o) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

@@ rtl/core/ptt_dp.sv @@
module ptt_dp
  import ptt_pkg::*;
#(
  parameter int unsigned NumTimers = NumTimersDefault,
  parameter int unsigned TimeBits  = TimeBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] interval_i,
  input  logic [RepW-1:0]    repeat_count_i,
  input  logic [IdW-1:0]     timer_id_i,
  input  ptt_cmd_t           cmd_i,
  output ptt_stat_t          stat_o,
  output logic [1:0]         status_o,
  output logic [IdW-1:0]     result_id_o,
  output logic signed [31:0] timeout_ms_o
);
  localparam int unsigned SlotW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned CntW  = $clog2(NumTimers + 1);

  logic [RegW-1:0] min_iv_q, max_iv_q, min_to_q;
  logic [TimeBits-1:0] now_q;
  logic [NumTimers-1:0] used_q;
  logic [RegW-1:0] period_q [NumTimers];
  logic [RepW-1:0] remain_q [NumTimers];
  logic [TimeBits-1:0] expiry_q [NumTimers];

  logic [1:0] req_q;
  logic signed [31:0] iv_q;
  logic [RepW-1:0] rep_q;
  logic [IdW-1:0] tid_q;
  logic [SlotW-1:0] idx_q;
  logic [NumTimers-1:0] fired_q;
  logic found_q;
  logic [SlotW-1:0] free_q;
  logic [TimeBits-1:0] best_q;
  logic any_q;
  logic [1:0] st_q;
  logic [IdW-1:0] rid_q;
  logic signed [31:0] to_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_iv_q <= RegW'(1);
      max_iv_q <= RegW'(60000);
      min_to_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinInterval: min_iv_q <= cfg_data_i;
        CfgMaxInterval: max_iv_q <= cfg_data_i;
        CfgMinTimeout:  min_to_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // current slot view
  logic [TimeBits-1:0] now_eff, diff, exp_next, d_pos, per_ext;
  logic cur_used, cur_due, cur_fire, cur_free_after, remain_one;
  assign now_eff   = (req_q == ReqTick) ? now_q + TimeBits'(1) : now_q;
  assign cur_used  = used_q[idx_q];
  assign diff      = expiry_q[idx_q] - now_eff;
  assign cur_due   = (diff == '0) || diff[TimeBits-1];
  assign cur_fire  = (req_q == ReqTick) && cur_used && cur_due;
  assign remain_one = (remain_q[idx_q] == RepW'(1));
  assign cur_free_after = cur_fire && remain_one;
  assign per_ext   = TimeBits'(period_q[idx_q]);
  assign exp_next  = cur_fire ? expiry_q[idx_q] + per_ext : expiry_q[idx_q];
  assign d_pos     = (exp_next - now_eff);
  assign stat_o.scan_last = (idx_q == SlotW'(NumTimers - 1));

  // remove effect on the timeout: excluded slot
  logic removing;
  assign removing = (req_q == ReqRemove) && (32'(tid_q) < 32'(NumTimers))
                    && (tid_q[SlotW-1:0] == idx_q) && cur_used;
  logic counts;
  assign counts = cur_used && !cur_free_after && !removing;

  // clamp of add interval
  logic signed [32:0] iv_s, min_s, max_s;
  logic [RegW-1:0] per_add;
  assign iv_s  = 33'(iv_q);
  assign min_s = $signed({2'b00, min_iv_q});
  assign max_s = $signed({2'b00, max_iv_q});
  always_comb begin
    if (iv_s < min_s) per_add = min_iv_q;
    else if (iv_s > max_s) per_add = max_iv_q;
    else per_add = iv_q[RegW-1:0];
  end

  // lowest fired id
  logic [SlotW-1:0] first_fire;
  always_comb begin
    first_fire = '0;
    for (int i = NumTimers - 1; i >= 0; i--)
      if (fired_q[i]) first_fire = SlotW'(i);
  end
  assign stat_o.fire_pend   = |fired_q;
  assign stat_o.fire_single = $onehot(fired_q);

  // timeout clamp from scan result, including the added slot
  logic [TimeBits-1:0] best_f, t_clamp;
  logic any_f, add_ok;
  assign add_ok = (req_q == ReqAdd) && found_q;
  always_comb begin
    best_f = best_q;
    any_f  = any_q || add_ok;
    if (add_ok && TimeBits'(per_add) < best_f) best_f = TimeBits'(per_add);
    if (best_f < TimeBits'(min_to_q)) t_clamp = TimeBits'(min_to_q);
    else if (best_f > TimeBits'(max_iv_q)) t_clamp = TimeBits'(max_iv_q);
    else t_clamp = best_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      used_q  <= '0;
      fired_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.start) begin
        req_q <= req_type_i;
        iv_q <= interval_i;
        rep_q <= repeat_count_i;
        tid_q <= timer_id_i;
        idx_q <= '0;
        fired_q <= '0;
        found_q <= 1'b0;
        free_q <= '0;
        any_q <= 1'b0;
        best_q <= TimeBits'(max_iv_q);
      end
      if (cmd_i.scan_en) begin
        if (!stat_o.scan_last) idx_q <= idx_q + SlotW'(1);
        if (!cur_used && !found_q) begin
          found_q <= 1'b1;
          free_q <= idx_q;
        end
        if (cur_fire) begin
          fired_q[idx_q] <= 1'b1;
          if (remain_q[idx_q] != '0) remain_q[idx_q] <= remain_q[idx_q] - RepW'(1);
          if (cur_free_after) used_q[idx_q] <= 1'b0;
          else expiry_q[idx_q] <= exp_next;
        end
        if (counts) begin
          any_q <= 1'b1;
          if (d_pos[TimeBits-1]) best_q <= '0;
          else if (d_pos < best_q) best_q <= d_pos;
        end
      end
      if (cmd_i.finish) begin
        now_q <= now_eff;
        st_q <= StOk;
        rid_q <= '0;
        to_q <= any_f ? $signed(t_clamp[31:0]) : -32'sd1;
        unique case (req_q)
          ReqAdd: if (found_q) begin
            used_q[free_q] <= 1'b1;
            period_q[free_q] <= per_add;
            remain_q[free_q] <= rep_q;
            expiry_q[free_q] <= now_q + TimeBits'(per_add);
            rid_q <= IdW'(free_q);
          end else st_q <= StFull;
          ReqRemove: begin
            rid_q <= tid_q;
            if ((32'(tid_q) < 32'(NumTimers)) && used_q[tid_q[SlotW-1:0]])
              used_q[tid_q[SlotW-1:0]] <= 1'b0;
            else st_q <= StNoTmr;
          end
          default: ;
        endcase
      end
      if (cmd_i.emit_adv && stat_o.fire_pend) fired_q[first_fire] <= 1'b0;
    end
  end

  assign status_o     = st_q;
  assign result_id_o  = stat_o.fire_pend ? IdW'(first_fire) : rid_q;
  assign timeout_ms_o = to_q;
endmodule

@@ rtl/core/periodic_timer_table.sv @@
// channel | dir | tdata (low to high)                          | tuser    | tlast
// s_axis  | in  | interval[31:0], repeat_count[47:32], id[51:48] | req_type | -
// m_axis  | out | status[1:0], result_id[5:2], timeout_ms[37:6] | fired    | last
// an item passes an accept state, a scan of all NUM_TIMERS slots (one slot per cycle,
// shared clamp and compare logic) and an apply state, then one result transfer per fired id, or one if none fired
// async active-low reset clears time, occupancy and config to defaults
// a stalled output holds the result; no input is taken until all results are out
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int unsigned NumTimers = NumTimersDefault,
  parameter int unsigned TimeBits  = TimeBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,  // interval, repeat_count, timer_id
  input  logic [1:0]         s_axis_tuser,  // req_type
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,  // status, result_id, timeout_ms
  output logic               m_axis_tuser,  // fired
  output logic               m_axis_tlast
);
  ptt_cmd_t cmd;
  ptt_stat_t stat;
  logic [1:0] status;
  logic [IdW-1:0] rid;
  logic signed [31:0] to;

  ptt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_last_o(m_axis_tlast), .out_fire_o(m_axis_tuser),
    .stat_i(stat), .cmd_o(cmd)
  );

  ptt_dp #(.NumTimers(NumTimers), .TimeBits(TimeBits)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i(s_axis_tuser),
    .interval_i($signed(s_axis_tdata[31:0])),
    .repeat_count_i(s_axis_tdata[47:32]),
    .timer_id_i(s_axis_tdata[51:48]),
    .cmd_i(cmd), .stat_o(stat),
    .status_o(status), .result_id_o(rid), .timeout_ms_o(to)
  );

  assign m_axis_tdata = {2'b00, to, rid, status};
endmodule

@@ rtl/core/ptt_checker.sv @@
module ptt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic m_axis_tlast
);
  // no input taken while results wait
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while output busy");
  // an accepted item is not answered in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early result");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");
  // last transfer reopens the input
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not reopened");
endmodule

bind periodic_timer_table ptt_checker u_chk (.*);
